>>> design/ts7seg_pkg.sv
// ----------------------------------------------------------------------------
// ts7seg_pkg
// Shared types, codes and glyph table for the temperature display unit.
// ----------------------------------------------------------------------------
package ts7seg_pkg;

  localparam logic [1:0] MODE_CELSIUS    = 2'd0;
  localparam logic [1:0] MODE_FAHRENHEIT = 2'd1;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_COLD = 2'd1;
  localparam logic [1:0] REG_HOT  = 2'd2;

  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_BLUE  = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_RED   = 2'd3;

  localparam logic [7:0] SEG_MINUS  = 8'h40;
  localparam logic [7:0] SEG_DEG_C  = 8'h58;
  localparam logic [7:0] SEG_DEG_F  = 8'h71;
  localparam logic [7:0] SEG_BLANK  = 8'h00;
  localparam logic [7:0] SEG_DOT    = 8'h80;

  localparam logic signed [7:0] COLD_RESET = 8'sd23;
  localparam logic signed [7:0] HOT_RESET  = 8'sd26;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [7:0] cold;
    logic signed [7:0] hot;
  } cfg_t;

  // whole/tenths are of the shown magnitude in tenths of a degree (q)
  typedef struct packed {
    logic [1:0]        mode;
    logic              neg;
    logic [11:0]       q;
    logic [8:0]        whole;
    logic signed [7:0] whole_c;
  } conv_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> design/temp_sensor_to_seven_segment_unit.sv
// ----------------------------------------------------------------------------
// temp_sensor_to_seven_segment_unit
// Sensor reading to four seven-segment digit writes plus status LED color.
// ----------------------------------------------------------------------------
// The first digit beat is valid once an accepted reading has passed the input
// stage register and then the result register. Each reading leaves the result
// register as four output beats, one per cycle while out_ready_i is high.
// A reading is accepted into the input stage while the previous one drains.
// Reset: pipeline empty, mode Celsius, cold limit 23, hot limit 26.
module temp_sensor_to_seven_segment_unit import ts7seg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] raw_high_i,
  input  logic [7:0] raw_low_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] digit_position_o,
  output logic [7:0] segments_o,
  output logic [1:0] led_color_o,
  output logic       last_write_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t            cfg;
  conv_t           conv;
  conv_t           mid_q;
  logic            mid_valid_q;
  logic [3:0][7:0] segs;
  logic [1:0]      led;
  logic [3:0][7:0] seg_q;
  logic [1:0]      led_q;
  logic            res_valid_q;
  logic [1:0]      cnt_q;
  logic            res_free;
  logic            mid_adv;
  logic            in_fire;
  logic            out_fire;

  ts7seg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ts7seg_front u_front (
    .raw_high_i (raw_high_i),
    .raw_low_i  (raw_low_i),
    .mode_i     (cfg.mode),
    .conv_o     (conv)
  );

  ts7seg_glyph u_glyph (
    .conv_i (mid_q),
    .cfg_i  (cfg),
    .segs_o (segs),
    .led_o  (led)
  );

  assign out_fire   = res_valid_q && out_ready_i;
  assign res_free   = !res_valid_q || (out_ready_i && cnt_q == 2'd3);
  assign mid_adv    = mid_valid_q && res_free;
  assign in_ready_o = !mid_valid_q || res_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      if (in_fire) mid_valid_q <= 1'b1;
      else if (mid_adv) mid_valid_q <= 1'b0;
      if (mid_adv) begin
        res_valid_q <= 1'b1;
        cnt_q       <= 2'd0;
      end else if (out_fire) begin
        if (cnt_q == 2'd3) res_valid_q <= 1'b0;
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) mid_q <= conv;
    if (mid_adv) begin
      seg_q <= segs;
      led_q <= led;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign digit_position_o = 3'd4 - {1'b0, cnt_q};
  assign segments_o       = seg_q[cnt_q];
  assign led_color_o      = led_q;
  assign last_write_o     = (cnt_q == 2'd3);

  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_write_o |=>
      out_valid_o && digit_position_o == $past(digit_position_o) - 3'd1)
    else $error("digit position did not step down within a reading");

  a_led_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_write_o |=> led_color_o == $past(led_color_o))
    else $error("LED color changed within a reading");

  a_standby_dash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && led_color_o == LED_OFF |-> segments_o == SEG_MINUS)
    else $error("LED off without dash pattern");

  a_in_to_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> mid_valid_q)
    else $error("accepted reading lost from input stage");

endmodule

>>> design/ts7seg_cfg.sv
// ----------------------------------------------------------------------------
// ts7seg_cfg
// Configuration registers: display mode and LED cold/hot limits.
// ----------------------------------------------------------------------------
module ts7seg_cfg import ts7seg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE: cfg_d.mode = cfg_data_i[1:0];
        REG_COLD: cfg_d.cold = $signed(cfg_data_i);
        REG_HOT:  cfg_d.hot  = $signed(cfg_data_i);
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_CELSIUS;
      cfg_q.cold <= COLD_RESET;
      cfg_q.hot  <= HOT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/ts7seg_front.sv
// ----------------------------------------------------------------------------
// ts7seg_front
// Reading conversion: sign, magnitude in tenths of a degree, whole part.
// ----------------------------------------------------------------------------
module ts7seg_front import ts7seg_pkg::*; (
  input  logic [7:0] raw_high_i,
  input  logic [7:0] raw_low_i,
  input  logic [1:0] mode_i,
  output conv_t      conv_o
);

  logic signed [11:0] s;
  logic [11:0]        a;
  logic signed [15:0] s16;
  logic signed [15:0] t;
  logic [14:0]        m;
  logic [13:0]        a5;
  logic [11:0]        q;
  logic [24:0]        prod;
  logic [7:0]         a4;
  logic               fahr;

  always_comb begin
    fahr = (mode_i == MODE_FAHRENHEIT);
    s    = $signed({raw_high_i, raw_low_i[7:4]});
    a    = s[11] ? (~s + 12'd1) : s;
    // Fahrenheit in 1/80 degree: 9*s + 2560
    s16  = 16'(s);
    t    = (s16 <<< 3) + s16 + 16'sd2560;
    m    = t[15] ? 15'(-t) : 15'(t);
    // Celsius in tenths: floor(a*5/8)
    a5   = {2'b00, a} + {a, 2'b00};
    q    = fahr ? m[14:3] : {1'b0, a5[13:3]};
    prod = 25'(q) * 25'd6554;
    a4   = a[11:4];

    conv_o.mode    = mode_i;
    conv_o.neg     = fahr ? t[15] : s[11];
    conv_o.q       = q;
    conv_o.whole   = prod[24:16];
    conv_o.whole_c = s[11] ? $signed(~a4 + 8'd1) : $signed(a4);
  end

endmodule

>>> design/ts7seg_glyph.sv
// ----------------------------------------------------------------------------
// ts7seg_glyph
// Digit split, segment sequence for the four writes, and LED color.
// ----------------------------------------------------------------------------
module ts7seg_glyph import ts7seg_pkg::*; (
  input  conv_t           conv_i,
  input  cfg_t            cfg_i,
  output logic [3:0][7:0] segs_o,
  output logic [1:0]      led_o
);

  logic [11:0]     w10;
  logic [3:0]      tenths;
  logic [15:0]     pd;
  logic [4:0]      d;
  logic [8:0]      d10;
  logic [3:0]      units;
  logic [1:0]      h;
  logic [4:0]      tens5;
  logic [1:0]      nd;
  logic            dp;
  logic            standby;
  logic [5:0][7:0] dl;
  logic [2:0]      idx;

  always_comb begin
    standby = conv_i.mode[1];
    w10     = {conv_i.whole, 3'b000} + {2'b00, conv_i.whole, 1'b0};
    tenths  = 4'(conv_i.q - w10);
    pd      = 16'(conv_i.whole) * 16'd205;
    d       = pd[15:11];
    d10     = {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
    units   = 4'(conv_i.whole - d10);
    if (d >= 5'd20) h = 2'd2;
    else if (d >= 5'd10) h = 2'd1;
    else h = 2'd0;
    tens5   = d - 5'({h, 3'b000} + {1'b0, h, 1'b0});
    if (conv_i.whole > 9'd99) nd = 2'd2;
    else if (conv_i.whole > 9'd9) nd = 2'd1;
    else nd = 2'd0;
    dp      = ({1'b0, nd} + {2'b00, conv_i.neg}) < 3'd3;

    dl[0] = digit_seg({2'b00, h});
    dl[1] = digit_seg(tens5[3:0]);
    dl[2] = digit_seg(units) | (dp ? SEG_DOT : SEG_BLANK);
    dl[3] = digit_seg(tenths);
    dl[4] = (conv_i.mode == MODE_FAHRENHEIT) ? SEG_DEG_F : SEG_DEG_C;
    dl[5] = SEG_BLANK;

    for (int k = 0; k < 4; k++) begin
      idx = 3'd2 - {1'b0, nd} + 3'(k) - {2'b00, conv_i.neg};
      if (standby || (conv_i.neg && k == 0)) begin
        segs_o[k] = SEG_MINUS;
      end else begin
        unique case (idx)
          3'd0:    segs_o[k] = dl[0];
          3'd1:    segs_o[k] = dl[1];
          3'd2:    segs_o[k] = dl[2];
          3'd3:    segs_o[k] = dl[3];
          3'd4:    segs_o[k] = dl[4];
          3'd5:    segs_o[k] = dl[5];
          default: segs_o[k] = SEG_BLANK;
        endcase
      end
    end

    priority if (standby)                  led_o = LED_OFF;
    else if (conv_i.whole_c <= cfg_i.cold) led_o = LED_BLUE;
    else if (conv_i.whole_c >= cfg_i.hot)  led_o = LED_RED;
    else                                   led_o = LED_GREEN;
  end

endmodule
